@@ rtl/core/hrc_pkg.sv @@
// ----------------------------------------------------------------------------
// hrc_pkg
// Types, codes and the byte-wide CRC-32 step shared by the hex record checker.
// ----------------------------------------------------------------------------
package hrc_pkg;

  // record framing
  localparam logic [7:0] MARKER_BYTE    = 8'h3A;
  localparam logic [7:0] POS_BODY       = 8'd5;
  localparam logic [7:0] POS_FIRST_PAST = 8'd13;
  localparam logic [7:0] POS_SATURATE   = 8'd254;
  localparam logic [7:0] POS_DONE       = 8'd255;

  // record types
  localparam logic [7:0] REC_DATA     = 8'h00;
  localparam logic [7:0] REC_EOF      = 8'h01;
  localparam logic [7:0] REC_EXT_LIN  = 8'h04;
  localparam logic [7:0] REC_START_LN = 8'h05;

  // status codes
  localparam logic [1:0] STATUS_OK  = 2'd0;
  localparam logic [1:0] STATUS_BAD = 2'd1;
  localparam logic [1:0] STATUS_EOF = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_FIRST_ADDR = 2'd0;
  localparam logic [1:0] CFG_ADDR_LIMIT = 2'd1;
  localparam logic [1:0] CFG_CRC_ADDR   = 2'd2;

  // configuration reset values
  localparam logic [31:0] FIRST_ADDR_RST = 32'h0001_0000;
  localparam logic [31:0] ADDR_LIMIT_RST = 32'h0010_0000;
  localparam logic [31:0] CRC_ADDR_RST   = 32'h000F_FFF0;

  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [7:0] record_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] running_crc;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  index;
    logic [31:0] data;
  } cfg_item_t;

  // reflected crc-32, one byte
  function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = {1'b0, c[31:1]} ^ (c[0] ? CRC_POLY : 32'd0);
    end
    return c;
  endfunction

endpackage

@@ rtl/core/hrc_stream_if.sv @@
// ----------------------------------------------------------------------------
// hrc_stream_if
// Valid/ready channel carrying one item of a given payload type.
// ----------------------------------------------------------------------------
interface hrc_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

@@ rtl/core/hrc_crc_check.sv @@
// ----------------------------------------------------------------------------
// hrc_crc_check
// Runs the first four stored image bytes through the crc, one byte per cycle,
// after every record end; the result then holds until the next restart.
// ----------------------------------------------------------------------------
module hrc_crc_check (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            restart_i,
  input  logic [31:0]     seed_i,
  input  logic [3:0][7:0] stored_i,
  output logic [31:0]     check_o
);

  logic [31:0] acc_q, acc_d;
  logic [2:0]  cnt_q, cnt_d;

  // one byte per cycle until the count reaches four
  always_comb begin
    acc_d = acc_q;
    cnt_d = cnt_q;
    if (restart_i) begin
      acc_d = seed_i;
      cnt_d = 3'd0;
    end else if (!cnt_q[2]) begin
      acc_d = hrc_pkg::crc32_byte(acc_q, stored_i[cnt_q[1:0]]);
      cnt_d = cnt_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= hrc_pkg::CRC_INIT;
      cnt_q <= 3'd0;
    end else begin
      acc_q <= acc_d;
      cnt_q <= cnt_d;
    end
  end

  // final invert
  assign check_o = ~acc_q;

endmodule

@@ rtl/core/hex_record_checker_crc32_core.sv @@
// ----------------------------------------------------------------------------
// hex_record_checker_crc32_core
// Checks binary hex records a byte at a time and keeps a running CRC-32.
// ----------------------------------------------------------------------------
// Flow: a record byte is registered in the input register, then processed; the
// status item of a record is written to the output register as its last byte is processed.
// Throughput: one byte per cycle; a last byte waits in the input register only
// while the previous status item is still held in the output register.
// Reset: asynchronous, active low; configuration returns to its defaults, the
// crc to all ones and all record state to zero.
module hex_record_checker_crc32_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  hrc_stream_if.sink          rec_i,
  hrc_stream_if.source        res_o,
  hrc_stream_if.sink          cfg_i
);

  // configuration registers
  logic [31:0] first_addr_q, addr_limit_q, crc_addr_q;

  // input register
  logic                s1_valid_q;
  hrc_pkg::in_item_t   s1_q;

  // output register
  logic                out_valid_q;
  hrc_pkg::out_item_t  out_q;

  // record state
  logic [7:0]      pos_q, pos_d;
  logic [7:0]      len_q, len_d;
  logic [7:0]      kind_q, kind_d;
  logic [15:0]     offset_q, offset_d;
  logic [7:0]      sum_q, sum_d;
  logic            fault_q, fault_d;
  logic [31:0]     pending_q, pending_d;
  logic [7:0][7:0] peb_q, peb_d;

  // image state
  logic [15:0]     upper_q, upper_d;
  logic [31:0]     committed_q, committed_d;
  logic [7:0][7:0] stored_q, stored_d;
  logic            seen_q, seen_d;

  logic        out_free, s1_fire, finish;
  logic [7:0]  b, sum_plus, idx;
  logic [1:0]  status;
  logic [31:0] full_addr, stored_word, check_crc;

  // handshakes
  assign out_free    = !out_valid_q || res_o.ready;
  assign s1_fire     = s1_valid_q && (!s1_q.last_byte || out_free);
  assign rec_i.ready = !s1_valid_q || s1_fire;
  assign cfg_i.ready = 1'b1;
  assign finish      = s1_fire && s1_q.last_byte;

  assign res_o.valid   = out_valid_q;
  assign res_o.payload = out_q;

  assign b           = s1_q.record_byte;
  assign sum_plus    = sum_q + b;
  assign idx         = pos_q - hrc_pkg::POS_BODY;
  assign full_addr   = {upper_q, offset_q};
  assign stored_word = {stored_q[7], stored_q[6], stored_q[5], stored_q[4]};

  // stored image crc check
  hrc_crc_check u_check (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .restart_i (finish),
    .seed_i    (committed_d),
    .stored_i  (stored_q[3:0]),
    .check_o   (check_crc)
  );

  // byte processing and record end
  always_comb begin
    pos_d       = pos_q;
    len_d       = len_q;
    kind_d      = kind_q;
    offset_d    = offset_q;
    sum_d       = sum_q;
    fault_d     = fault_q;
    pending_d   = pending_q;
    peb_d       = peb_q;
    upper_d     = upper_q;
    committed_d = committed_q;
    stored_d    = stored_q;
    seen_d      = seen_q;
    status      = hrc_pkg::STATUS_BAD;

    if (pos_q == hrc_pkg::POS_DONE) begin
      fault_d = 1'b1;
    end else if (pos_q < hrc_pkg::POS_BODY) begin
      case (pos_q[2:0])
        3'd0: begin
          if (b != hrc_pkg::MARKER_BYTE) fault_d = 1'b1;
        end
        3'd1: len_d = b;
        3'd2: offset_d[15:8] = b;
        3'd3: offset_d[7:0] = b;
        default: kind_d = b;
      endcase
      if (pos_q != 8'd0) sum_d = sum_plus;
      pos_d = pos_q + 8'd1;
    end else if (len_q == 8'd0) begin
      // checksum byte
      if (sum_plus != 8'd0) fault_d = 1'b1;
      pos_d = hrc_pkg::POS_DONE;
    end else begin
      // data byte
      if (pos_q < hrc_pkg::POS_FIRST_PAST) peb_d[idx[2:0]] = b;
      pending_d = hrc_pkg::crc32_byte(pending_q, b);
      sum_d     = sum_plus;
      len_d     = len_q - 8'd1;
      if (pos_q < hrc_pkg::POS_SATURATE) pos_d = pos_q + 8'd1;
    end

    if (s1_q.last_byte) begin
      if (!fault_d && pos_d == hrc_pkg::POS_DONE) begin
        case (kind_q)
          hrc_pkg::REC_EXT_LIN: begin
            upper_d = {peb_q[0], peb_q[1]};
            status  = hrc_pkg::STATUS_OK;
          end
          hrc_pkg::REC_DATA: begin
            if (full_addr >= addr_limit_q || full_addr < first_addr_q) begin
              status = hrc_pkg::STATUS_BAD;
            end else begin
              status = hrc_pkg::STATUS_OK;
              if (full_addr == crc_addr_q) begin
                stored_d = peb_q;
                seen_d   = 1'b1;
              end else begin
                committed_d = pending_q;
              end
            end
          end
          hrc_pkg::REC_EOF: begin
            status = (seen_q && check_crc == stored_word) ? hrc_pkg::STATUS_EOF
                                                          : hrc_pkg::STATUS_BAD;
          end
          hrc_pkg::REC_START_LN: status = hrc_pkg::STATUS_OK;
          default: status = hrc_pkg::STATUS_BAD;
        endcase
      end
      // next record starts fresh
      pos_d     = 8'd0;
      len_d     = 8'd0;
      kind_d    = 8'd0;
      offset_d  = 16'd0;
      sum_d     = 8'd0;
      fault_d   = 1'b0;
      pending_d = committed_d;
      peb_d     = '0;
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (rec_i.ready) begin
      s1_valid_q <= rec_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rec_i.ready && rec_i.valid) s1_q <= rec_i.payload;
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (finish) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish) begin
      out_q.status      <= status;
      out_q.running_crc <= committed_d;
    end
  end

  // record and image state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= 8'd0;
      len_q       <= 8'd0;
      kind_q      <= 8'd0;
      offset_q    <= 16'd0;
      sum_q       <= 8'd0;
      fault_q     <= 1'b0;
      pending_q   <= hrc_pkg::CRC_INIT;
      peb_q       <= '0;
      upper_q     <= 16'd0;
      committed_q <= hrc_pkg::CRC_INIT;
      stored_q    <= '0;
      seen_q      <= 1'b0;
    end else if (s1_fire) begin
      pos_q       <= pos_d;
      len_q       <= len_d;
      kind_q      <= kind_d;
      offset_q    <= offset_d;
      sum_q       <= sum_d;
      fault_q     <= fault_d;
      pending_q   <= pending_d;
      peb_q       <= peb_d;
      upper_q     <= upper_d;
      committed_q <= committed_d;
      stored_q    <= stored_d;
      seen_q      <= seen_d;
    end
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_addr_q <= hrc_pkg::FIRST_ADDR_RST;
      addr_limit_q <= hrc_pkg::ADDR_LIMIT_RST;
      crc_addr_q   <= hrc_pkg::CRC_ADDR_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.payload.index)
        hrc_pkg::CFG_FIRST_ADDR: first_addr_q <= cfg_i.payload.data;
        hrc_pkg::CFG_ADDR_LIMIT: addr_limit_q <= cfg_i.payload.data;
        hrc_pkg::CFG_CRC_ADDR:   crc_addr_q   <= cfg_i.payload.data;
        default: ;
      endcase
    end
  end

endmodule

@@ verif/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the hex record checker. Byte streams of whole
// records are built (images: extended address, data records, type 5, the
// record that carries the image crc, end of file) mixed with broken records
// and stray records. A byte-level model of the checker runs on every
// accepted byte and queues the status item that the core must produce.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned   CYCLE_LIMIT     = 200000;
  localparam int unsigned   MIN_ITEMS       = 650;
  localparam int unsigned   HOLD_OFF_CYCLES = 300;
  localparam logic [31:0]   CRC32_REFL_POLY = 32'hEDB8_8320;
  localparam logic [7:0]    BODY_AT         = 8'd5;
  localparam logic [7:0]    SATURATE_AT     = 8'd254;
  localparam logic [7:0]    DONE_AT         = 8'd255;

  typedef logic [7:0] byte_q_t[$];
  typedef enum int {
    FLAW_NONE, FLAW_MARKER, FLAW_CHECKSUM, FLAW_SHORT, FLAW_LONG, FLAW_LENGTH
  } flaw_e;

  logic clk_i = 1'b0;
  logic rst_ni;

  hrc_stream_if #(.payload_t(hrc_pkg::in_item_t))  rec_if ();
  hrc_stream_if #(.payload_t(hrc_pkg::out_item_t)) res_if ();
  hrc_stream_if #(.payload_t(hrc_pkg::cfg_item_t)) cfg_if ();

  hex_record_checker_crc32_core u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rec_i  (rec_if),
    .res_o  (res_if),
    .cfg_i  (cfg_if)
  );

  // clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // pending record bytes and status items still to come
  hrc_pkg::in_item_t  byte_stream[$];
  hrc_pkg::out_item_t expected_status[$];
  int unsigned queued_items = 0;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  bit          hold_off;
  bit          calm;

  // model copy of the configuration
  logic [31:0] cfg_first, cfg_limit, cfg_crc_addr;

  // model state of the checker
  logic [7:0]  rec_pos, rec_len, rec_kind, rec_sum;
  logic [15:0] rec_offset, lead_pair, upper_addr;
  logic        rec_bad, crc_rec_seen;
  logic [31:0] image_crc, work_crc;
  logic [7:0]  head_bytes [8];
  logic [7:0]  kept_bytes [8];

  // upper address as the stream being built will leave it
  logic [15:0] gen_upper;

  bit                 step_made;
  hrc_pkg::out_item_t step_result;
  hrc_pkg::out_item_t oldest;

  // reflected crc-32, one byte, lsb first
  function automatic logic [31:0] crc32_reflected(input logic [31:0] acc,
                                                  input logic [7:0] data);
    logic [31:0] r;
    int          i;
    r = acc;
    for (i = 0; i < 8; i++) begin
      if (r[0] ^ data[i]) r = (r >> 1) ^ CRC32_REFL_POLY;
      else r = r >> 1;
    end
    return r;
  endfunction

  function automatic void clear_record();
    rec_pos    = 8'd0;
    rec_len    = 8'd0;
    rec_kind   = 8'd0;
    rec_offset = 16'd0;
    rec_sum    = 8'd0;
    rec_bad    = 1'b0;
    work_crc   = image_crc;
    lead_pair  = 16'd0;
    head_bytes = '{default: 8'h00};
  endfunction

  // status of a record that framed correctly
  function automatic logic [1:0] close_record();
    logic [31:0] full, stored, calc;
    int          k;
    case (rec_kind)
      hrc_pkg::REC_EXT_LIN: begin
        upper_addr = lead_pair;
        return hrc_pkg::STATUS_OK;
      end
      hrc_pkg::REC_DATA: begin
        full = {upper_addr, 16'h0000} + {16'h0000, rec_offset};
        if (full >= cfg_limit || full < cfg_first) return hrc_pkg::STATUS_BAD;
        if (full == cfg_crc_addr) begin
          kept_bytes   = head_bytes;
          crc_rec_seen = 1'b1;
        end else begin
          image_crc = work_crc;
        end
        return hrc_pkg::STATUS_OK;
      end
      hrc_pkg::REC_EOF: begin
        if (!crc_rec_seen) return hrc_pkg::STATUS_BAD;
        stored = {kept_bytes[7], kept_bytes[6], kept_bytes[5], kept_bytes[4]};
        calc = image_crc;
        for (k = 0; k < 4; k++) calc = crc32_reflected(calc, kept_bytes[k]);
        return (~calc == stored) ? hrc_pkg::STATUS_EOF : hrc_pkg::STATUS_BAD;
      end
      hrc_pkg::REC_START_LN: return hrc_pkg::STATUS_OK;
      default: return hrc_pkg::STATUS_BAD;
    endcase
  endfunction

  // one accepted byte through the model
  function automatic void step_record_model(input hrc_pkg::in_item_t it, output bit made,
                                            output hrc_pkg::out_item_t res);
    logic [7:0] b, idx, total;
    b    = it.record_byte;
    made = 1'b0;
    res  = '0;
    if (rec_pos == DONE_AT) begin
      rec_bad = 1'b1;
    end else if (rec_pos < BODY_AT) begin
      case (rec_pos)
        8'd0: if (b != hrc_pkg::MARKER_BYTE) rec_bad = 1'b1;
        8'd1: rec_len = b;
        8'd2: rec_offset = {b, 8'h00};
        8'd3: rec_offset[7:0] = b;
        default: rec_kind = b;
      endcase
      if (rec_pos != 8'd0) rec_sum = rec_sum + b;
      rec_pos = rec_pos + 8'd1;
    end else if (rec_len == 8'd0) begin
      total = rec_sum + b;
      if (total != 8'd0) rec_bad = 1'b1;
      rec_pos = DONE_AT;
    end else begin
      idx = rec_pos - BODY_AT;
      if (idx < 8'd8) head_bytes[idx[2:0]] = b;
      if (idx == 8'd0) lead_pair = {b, 8'h00};
      else if (idx == 8'd1) lead_pair[7:0] = b;
      work_crc = crc32_reflected(work_crc, b);
      rec_sum  = rec_sum + b;
      rec_len  = rec_len - 8'd1;
      if (rec_pos < SATURATE_AT) rec_pos = rec_pos + 8'd1;
    end
    if (it.last_byte) begin
      made = 1'b1;
      res.status = (rec_bad || rec_pos != DONE_AT) ? hrc_pkg::STATUS_BAD : close_record();
      res.running_crc = image_crc;
      clear_record();
    end
  endfunction

  function automatic byte_q_t random_bytes(input int n);
    byte_q_t q;
    int      i;
    for (i = 0; i < n; i++) q.push_back(8'($urandom_range(0, 255)));
    return q;
  endfunction

  // frame one record, optionally damage it, and queue its bytes
  task automatic queue_record(input logic [7:0] kind, input logic [15:0] offset,
                              input byte_q_t body, input flaw_e flaw);
    byte_q_t           frame;
    logic [7:0]        sum, delta;
    hrc_pkg::in_item_t it;
    int                i, keep;
    frame.push_back(hrc_pkg::MARKER_BYTE);
    frame.push_back(8'(body.size()));
    frame.push_back(offset[15:8]);
    frame.push_back(offset[7:0]);
    frame.push_back(kind);
    frame = {frame, body};
    sum = 8'h00;
    for (i = 1; i < frame.size(); i++) sum = sum + frame[i];
    frame.push_back(8'h00 - sum);
    case (flaw)
      FLAW_MARKER: begin
        frame[0] = 8'($urandom_range(0, 255));
        if (frame[0] == hrc_pkg::MARKER_BYTE) frame[0] = 8'h00;
      end
      FLAW_CHECKSUM: frame[frame.size() - 1] ^= 8'($urandom_range(1, 255));
      FLAW_SHORT: begin
        keep = $urandom_range(1, frame.size() - 1);
        while (frame.size() > keep) void'(frame.pop_back());
      end
      FLAW_LONG: repeat ($urandom_range(1, 3)) frame.push_back(8'($urandom_range(0, 255)));
      FLAW_LENGTH: begin
        // keep the sum right so only the length is off
        delta = 8'($urandom_range(1, 255));
        frame[1] = frame[1] + delta;
        frame[frame.size() - 1] = frame[frame.size() - 1] - delta;
      end
      default: ;
    endcase
    for (i = 0; i < frame.size(); i++) begin
      it.record_byte = frame[i];
      it.last_byte   = (i == frame.size() - 1);
      byte_stream.push_back(it);
    end
    queued_items += frame.size();
  endtask

  // extended linear address record when the upper half changes
  task automatic select_upper(input logic [31:0] full);
    byte_q_t body;
    if (full[31:16] != gen_upper) begin
      body.push_back(full[31:24]);
      body.push_back(full[23:16]);
      queue_record(hrc_pkg::REC_EXT_LIN, 16'h0000, body, FLAW_NONE);
      gen_upper = full[31:16];
    end
  endtask

  // random record; a harmless one leaves the model state as it is
  task automatic queue_stray_record(input bit harmless);
    logic [7:0] kind;
    flaw_e      flaw;
    byte_q_t    body;
    case ($urandom_range(0, 4))
      0: kind = hrc_pkg::REC_DATA;
      1: kind = hrc_pkg::REC_EOF;
      2: kind = hrc_pkg::REC_EXT_LIN;
      3: kind = hrc_pkg::REC_START_LN;
      default: kind = 8'($urandom_range(0, 255));
    endcase
    body = random_bytes($urandom_range(0, 10));
    if (harmless) begin
      if ($urandom_range(0, 5) == 0) begin
        // well framed but of an unknown type
        if (kind == hrc_pkg::REC_DATA || kind == hrc_pkg::REC_EOF ||
            kind == hrc_pkg::REC_EXT_LIN || kind == hrc_pkg::REC_START_LN)
          kind = kind ^ 8'h80;
        flaw = FLAW_NONE;
      end else begin
        flaw = flaw_e'($urandom_range(FLAW_MARKER, FLAW_LENGTH));
      end
    end else begin
      flaw = $urandom_range(0, 1) ? FLAW_NONE : flaw_e'($urandom_range(FLAW_MARKER, FLAW_LENGTH));
    end
    queue_record(kind, 16'($urandom), body, flaw);
  endtask

  task automatic write_register(input logic [1:0] idx, input logic [31:0] value);
    hrc_pkg::cfg_item_t w;
    w.index = idx;
    w.data  = value;
    @(posedge clk_i);
    cfg_if.valid   <= 1'b1;
    cfg_if.payload <= w;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    case (idx)
      hrc_pkg::CFG_FIRST_ADDR: cfg_first = value;
      hrc_pkg::CFG_ADDR_LIMIT: cfg_limit = value;
      hrc_pkg::CFG_CRC_ADDR:   cfg_crc_addr = value;
      default: ;
    endcase
  endtask

  // all bytes sent and every status item back, then let the pipe settle
  task automatic wait_idle();
    while (byte_stream.size() != 0 || rec_if.valid || expected_status.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // byte driver, model runs on each accepted item
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rec_if.valid   <= 1'b0;
      rec_if.payload <= '0;
    end else begin
      if (rec_if.valid && rec_if.ready) begin
        step_record_model(rec_if.payload, step_made, step_result);
        if (step_made) expected_status.push_back(step_result);
      end
      if (!rec_if.valid || rec_if.ready) begin
        if (byte_stream.size() != 0 && (calm || $urandom_range(0, 99) >= 21)) begin
          rec_if.valid   <= 1'b1;
          rec_if.payload <= byte_stream.pop_front();
        end else begin
          rec_if.valid <= 1'b0;
        end
      end
    end
  end

  // status monitor and compare
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (expected_status.size() == 0) begin
          $display("%0t: unexpected status item, status %0d crc %08h", $time,
                   res_if.payload.status, res_if.payload.running_crc);
          mismatches++;
        end else begin
          oldest = expected_status.pop_front();
          if (res_if.payload.status !== oldest.status) begin
            $display("%0t: status mismatch, expected %0d, actual %0d", $time,
                     oldest.status, res_if.payload.status);
            mismatches++;
          end
          if (res_if.payload.running_crc !== oldest.running_crc) begin
            $display("%0t: running crc mismatch, expected %08h, actual %08h", $time,
                     oldest.running_crc, res_if.payload.running_crc);
            mismatches++;
          end
        end
      end
      res_if.ready <= !hold_off && (calm || $urandom_range(0, 99) >= 21);
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // stimulus
  initial begin
    byte_q_t     none, body;
    int          phase, n_data, k, len;
    logic [31:0] base, full, span, calc, mirror_crc;

    rst_ni         = 1'b0;
    rec_if.valid   = 1'b0;
    rec_if.payload = '0;
    res_if.ready   = 1'b0;
    cfg_if.valid   = 1'b0;
    cfg_if.payload = '0;
    hold_off       = 1'b0;
    calm           = 1'b0;
    cfg_first      = 32'h0001_0000;
    cfg_limit      = 32'h0010_0000;
    cfg_crc_addr   = 32'h000F_FFF0;
    upper_addr     = 16'd0;
    image_crc      = 32'hFFFF_FFFF;
    kept_bytes     = '{default: 8'h00};
    crc_rec_seen   = 1'b0;
    clear_record();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: end of file before any crc record, broken framing, short type 4
    queue_record(hrc_pkg::REC_EOF, 16'h0000, none, FLAW_NONE);
    queue_record(hrc_pkg::REC_START_LN, 16'hFFFF, none, FLAW_MARKER);
    queue_record(hrc_pkg::REC_DATA, 16'h0000, random_bytes(2), FLAW_SHORT);
    queue_record(hrc_pkg::REC_EXT_LIN, 16'h0000, none, FLAW_NONE);
    queue_record(hrc_pkg::REC_START_LN, 16'hFFFF, none, FLAW_LONG);
    queue_record(hrc_pkg::REC_EOF, 16'h0000, none, FLAW_CHECKSUM);
    wait_idle();

    for (phase = 1; phase <= 5 || queued_items < MIN_ITEMS; phase++) begin
      // new settings while idle
      case (phase)
        1: begin
          write_register(hrc_pkg::CFG_FIRST_ADDR, 32'h0000_0000);
          write_register(hrc_pkg::CFG_ADDR_LIMIT, 32'hFFFF_FFFF);
          write_register(hrc_pkg::CFG_CRC_ADDR, 32'hFFFF_FFF0);
        end
        2: begin
          write_register(hrc_pkg::CFG_ADDR_LIMIT, 32'h0001_0000);
          write_register(hrc_pkg::CFG_CRC_ADDR, 32'h0000_FF00);
        end
        3: begin
          write_register(hrc_pkg::CFG_FIRST_ADDR, 32'hFFFF_FFFF);
          write_register(hrc_pkg::CFG_ADDR_LIMIT, 32'hFFFF_FFFF);
          write_register(hrc_pkg::CFG_CRC_ADDR, 32'h0000_0000);
        end
        4: begin
          write_register(hrc_pkg::CFG_FIRST_ADDR, 32'h0000_0000);
          write_register(hrc_pkg::CFG_ADDR_LIMIT, 32'h0000_0000);
          write_register(hrc_pkg::CFG_CRC_ADDR, 32'hFFFF_FFFF);
        end
        5: begin
          write_register(hrc_pkg::CFG_FIRST_ADDR, 32'h0001_0000);
          write_register(hrc_pkg::CFG_ADDR_LIMIT, 32'h0010_0000);
          write_register(hrc_pkg::CFG_CRC_ADDR, 32'h000F_FFF0);
        end
        default: begin
          base = $urandom & 32'hFFFF_FFF0;
          write_register(hrc_pkg::CFG_FIRST_ADDR, base);
          write_register(hrc_pkg::CFG_ADDR_LIMIT, base + $urandom_range(16, 32'h0002_0000));
          write_register(hrc_pkg::CFG_CRC_ADDR, base + (32'($urandom_range(0, 255)) << 4));
        end
      endcase
      calm <= (phase == 2);

      // image: data records, type 5, crc record, end of file
      mirror_crc = image_crc;
      gen_upper  = upper_addr;
      if (cfg_limit > cfg_first) begin
        span = cfg_limit - cfg_first;
        base = cfg_first + ($urandom % span);
      end else begin
        base = $urandom;
      end
      n_data = $urandom_range(1, 4);
      for (k = 0; k < n_data; k++) begin
        if ($urandom_range(0, 6) == 0) begin
          // range edges
          case ($urandom_range(0, 3))
            0: full = cfg_first;
            1: full = cfg_first - 1;
            2: full = cfg_limit - 1;
            default: full = cfg_limit;
          endcase
        end else begin
          full = base + 32'(k * 16);
        end
        if (full != cfg_crc_addr) begin
          if (phase == 1 && k == 0) len = 255;
          else if ($urandom_range(0, 39) == 0) len = $urandom_range(240, 255);
          else len = $urandom_range(0, 16);
          body = random_bytes(len);
          select_upper(full);
          queue_record(hrc_pkg::REC_DATA, full[15:0], body, FLAW_NONE);
          if (full >= cfg_first && full < cfg_limit)
            foreach (body[i]) mirror_crc = crc32_reflected(mirror_crc, body[i]);
        end
        if ($urandom_range(0, 2) == 0) queue_stray_record(1'b1);
      end
      queue_record(hrc_pkg::REC_START_LN, 16'h0000, random_bytes(4), FLAW_NONE);

      // stored crc: bytes 4..7 little endian, now and then damaged, cut or lengthened
      body = random_bytes(4);
      calc = mirror_crc;
      for (k = 0; k < 4; k++) calc = crc32_reflected(calc, body[k]);
      calc = ~calc;
      body.push_back(calc[7:0]);
      body.push_back(calc[15:8]);
      body.push_back(calc[23:16]);
      body.push_back(calc[31:24]);
      if ($urandom_range(0, 4) == 0) body[$urandom_range(0, 7)] ^= 8'($urandom_range(1, 255));
      if ($urandom_range(0, 7) == 0) begin
        len = $urandom_range(0, 7);
        while (body.size() > len) void'(body.pop_back());
      end else if ($urandom_range(0, 7) == 0) begin
        body = {body, random_bytes($urandom_range(1, 4))};
      end
      select_upper(cfg_crc_addr);
      queue_record(hrc_pkg::REC_DATA, cfg_crc_addr[15:0], body, FLAW_NONE);
      queue_record(hrc_pkg::REC_EOF, 16'h0000, none, FLAW_NONE);
      repeat ($urandom_range(1, 2)) queue_stray_record(1'b0);

      // output held off while bytes keep coming
      if (phase == 1) begin
        hold_off <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
        hold_off <= 1'b0;
      end
      wait_idle();
    end

    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && expected_status.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
